>>> hw/rtl/keyed_response_queue_assert.svh
// Assertion macros for the keyed response queue checker
`ifndef KEYED_RESPONSE_QUEUE_ASSERT_SVH
`define KEYED_RESPONSE_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define KRQ_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define KRQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/krq_pkg.sv
// Types and constants shared by the keyed response queue modules
package krq_pkg;

  localparam int ID_W   = 11;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int NODE_W = 7;
  localparam int KEY_W  = 12;
  localparam int IDX_W  = 16;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic             OP_PUSH = 1'b0;
  localparam logic             OP_TAKE = 1'b1;
  localparam logic [CFG_AW-3:0] REG_RESPONSE_ID_BASE = 1'b0;
  localparam logic [ID_W-1:0]  BASE_RESET = 11'd1408;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_COMPACT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;   // latch the accepted transaction
    logic push;      // append frame, drop oldest if full
    logic scan;      // search step
    logic hit_take;  // latch the matching entry, start compaction
    logic compact;   // move step
    logic remove;    // shrink queue by one
    logic load_out;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic hit;      // compared entry matches
    logic drained;  // nothing left to issue, nothing in flight
  } sts_t;

endpackage

>>> hw/rtl/keyed_response_queue.sv
// Keyed response queue: a ring of up to QUEUE_DEPTH received CAN frames in arrival
// order. A push transaction appends a frame (dropping the oldest when full). A take
// transaction reads the stored frames one per cycle from oldest to newest through
// the single read port of the frame memory until the first whose identifier equals
// response_id_base + node and whose bytes 1-2 equal want_index, then moves each
// later frame down one place, again one per cycle. One transaction is processed at
// a time; a new one is taken while the previous result still waits in the output
// register. response_id_base is at address 0.
module keyed_response_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [krq_pkg::ID_W-1:0]           in_frame_id,
  input  logic [krq_pkg::LEN_W-1:0]          in_frame_len,
  input  logic [krq_pkg::DATA_W-1:0]         in_frame_data,
  input  logic [krq_pkg::NODE_W-1:0]         in_node,
  input  logic [krq_pkg::IDX_W-1:0]          in_want_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic                               out_dropped_oldest,
  output logic [krq_pkg::ID_W-1:0]           out_id,
  output logic [krq_pkg::LEN_W-1:0]          out_len,
  output logic [krq_pkg::DATA_W-1:0]         out_data,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_fill_count,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [krq_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [krq_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [krq_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);
  import krq_pkg::*;

  logic [ID_W-1:0] base_r;
  logic            sel_base;
  cmd_t            cmd;
  sts_t            sts;

  assign sel_base   = (cfg_paddr[CFG_AW-1:2] == REG_RESPONSE_ID_BASE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = sel_base ? CFG_DW'(base_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && sel_base) begin
      base_r <= cfg_pwdata[ID_W-1:0];
    end
  end

  krq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  krq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_frame_id        (in_frame_id),
    .in_frame_len       (in_frame_len),
    .in_frame_data      (in_frame_data),
    .in_node            (in_node),
    .in_want_index      (in_want_index),
    .base               (base_r),
    .cmd                (cmd),
    .sts                (sts),
    .out_found          (out_found),
    .out_dropped_oldest (out_dropped_oldest),
    .out_id             (out_id),
    .out_len            (out_len),
    .out_data           (out_data),
    .out_fill_count     (out_fill_count)
  );

endmodule

>>> hw/rtl/krq_ctrl.sv
// Controller state machine of the keyed response queue
module krq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_stall,
  input  logic           out_stall,
  output logic           out_valid,
  input  krq_pkg::sts_t  sts,
  output krq_pkg::cmd_t  cmd
);
  import krq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_op == OP_PUSH) ? ST_PUSH : ST_SCAN;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.hit_take = 1'b1;
          state_nxt    = ST_COMPACT;
        end else if (sts.drained) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_COMPACT: begin
        cmd.compact = 1'b1;
        if (sts.drained) begin
          cmd.remove = 1'b1;
          state_nxt  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (!(out_valid_r && out_stall)) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/krq_dpath.sv
// Datapath of the keyed response queue: frame memory, pointers, search and compaction
module krq_dpath #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [krq_pkg::ID_W-1:0]              in_frame_id,
  input  logic [krq_pkg::LEN_W-1:0]             in_frame_len,
  input  logic [krq_pkg::DATA_W-1:0]            in_frame_data,
  input  logic [krq_pkg::NODE_W-1:0]            in_node,
  input  logic [krq_pkg::IDX_W-1:0]             in_want_index,
  input  logic [krq_pkg::ID_W-1:0]              base,
  input  krq_pkg::cmd_t                         cmd,
  output krq_pkg::sts_t                         sts,
  output logic                                  out_found,
  output logic                                  out_dropped_oldest,
  output logic [krq_pkg::ID_W-1:0]              out_id,
  output logic [krq_pkg::LEN_W-1:0]             out_len,
  output logic [krq_pkg::DATA_W-1:0]            out_data,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      out_fill_count
);
  import krq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] pos,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(pos) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) sum = sum - (CW+1)'(QUEUE_DEPTH);
    return sum[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] inc_pos(input logic [IW-1:0] pos);
    return (pos == IW'(QUEUE_DEPTH - 1)) ? '0 : pos + 1'b1;
  endfunction

  function automatic logic [IW-1:0] dec_pos(input logic [IW-1:0] pos);
    return (pos == '0) ? IW'(QUEUE_DEPTH - 1) : pos - 1'b1;
  endfunction

  entry_t mem [QUEUE_DEPTH];

  logic [IW-1:0]    oldest_r, next_free_r;
  logic [CW-1:0]    held_r;
  logic [CW-1:0]    off_r;      // next offset to read
  logic [CW-1:0]    roff_r;     // offset of the entry in rd_data_r
  logic             rv_r;       // rd_data_r holds a fresh read
  entry_t           rd_data_r;
  entry_t           frm_r;
  logic [KEY_W-1:0] key_r;
  logic [IDX_W-1:0] want_r;
  logic             res_found_r, res_drop_r;
  entry_t           res_entry_r;

  logic             full;
  logic             issue;
  logic [IW-1:0]    rd_addr, mv_addr, mem_waddr;
  logic             mem_we;
  entry_t           mem_wdata;
  logic             match;

  assign full    = (held_r == CW'(QUEUE_DEPTH));
  assign issue   = (cmd.scan || cmd.compact) && !cmd.hit_take && (off_r < held_r);
  assign rd_addr = slot_of(oldest_r, off_r);
  assign mv_addr = slot_of(oldest_r, roff_r - CW'(1));
  assign match   = ({1'b0, rd_data_r.id} == key_r) && (rd_data_r.data[23:8] == want_r);

  assign sts.hit     = rv_r && match;
  assign sts.drained = !rv_r && (off_r >= held_r);

  assign mem_we    = cmd.push || (cmd.compact && rv_r);
  assign mem_waddr = cmd.push ? next_free_r : mv_addr;
  assign mem_wdata = cmd.push ? frm_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
      roff_r    <= off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      next_free_r <= '0;
      held_r      <= '0;
      off_r       <= '0;
      rv_r        <= 1'b0;
    end else begin
      if (cmd.capture) begin
        off_r <= '0;
        rv_r  <= 1'b0;
      end
      if (cmd.push) begin
        if (full) begin
          oldest_r <= inc_pos(oldest_r);
        end else begin
          held_r <= held_r + 1'b1;
        end
        next_free_r <= inc_pos(next_free_r);
      end
      // compaction starts at the entry after the hit
      if (cmd.hit_take) begin
        off_r <= roff_r + 1'b1;
        rv_r  <= 1'b0;
      end else if (cmd.scan || cmd.compact) begin
        rv_r <= issue;
        if (issue) begin
          off_r <= off_r + 1'b1;
        end
      end
      if (cmd.remove) begin
        held_r      <= held_r - 1'b1;
        next_free_r <= dec_pos(next_free_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      frm_r       <= '{id: in_frame_id, len: in_frame_len, data: in_frame_data};
      key_r       <= KEY_W'(base) + KEY_W'(in_node);
      want_r      <= in_want_index;
      res_found_r <= 1'b0;
      res_drop_r  <= 1'b0;
      res_entry_r <= '0;
    end
    if (cmd.push && full) begin
      res_drop_r <= 1'b1;
    end
    if (cmd.hit_take) begin
      res_found_r <= 1'b1;
      res_entry_r <= rd_data_r;
    end
    if (cmd.load_out) begin
      out_found          <= res_found_r;
      out_dropped_oldest <= res_drop_r;
      out_id             <= res_entry_r.id;
      out_len            <= res_entry_r.len;
      out_data           <= res_entry_r.data;
      out_fill_count     <= held_r;
    end
  end

endmodule

>>> hw/rtl/keyed_response_queue_chk.sv
// Port-level checker for the keyed response queue, bound to the top level
`include "keyed_response_queue_assert.svh"

module keyed_response_queue_chk #(
  parameter int QUEUE_DEPTH = 32
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_found,
  input logic                               out_dropped_oldest,
  input logic [krq_pkg::ID_W-1:0]           out_id,
  input logic [krq_pkg::LEN_W-1:0]          out_len,
  input logic [krq_pkg::DATA_W-1:0]         out_data,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_fill_count
);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  logic frame_zero;

  assign frame_zero = (out_id == '0) && (out_len == '0) && (out_data == '0);

  // a stalled result stays presented
  `KRQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // one transaction at a time: busy right after an accept
  `KRQ_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted back to back")

  `KRQ_ASSERT(a_fill_bound, out_valid, out_fill_count <= FW'(QUEUE_DEPTH), "fill count above depth")

  // no removed frame means an all-zero frame field set, and a hit never drops
  `KRQ_ASSERT(a_miss_zero, out_valid && !out_found, frame_zero, "frame fields set without a hit")
  `KRQ_ASSERT(a_hit_no_drop, out_valid && out_found, !out_dropped_oldest, "take reported a drop")

endmodule

bind keyed_response_queue keyed_response_queue_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (.*);
